// ===== rtl/core/rpcr_pkg.sv =====
// Shared types, constants and codes for the RAID parity column rebuild block.
package rpcr_pkg;

    localparam int MAX_DISKS      = 6;
    localparam int MAX_BLOCK_BITS = 64;
    localparam int DISK_W         = $clog2(MAX_DISKS);
    localparam int BITS_W         = $clog2(MAX_BLOCK_BITS + 1);
    localparam int COL_W          = $clog2(MAX_BLOCK_BITS);
    localparam int CNT_W          = $clog2(MAX_DISKS + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [2:0]        RST_DISK_COUNT = 3'd6;
    localparam logic              RST_PARITY_ODD = 1'b0;
    localparam logic [BITS_W-1:0] RST_BLOCK_BITS = BITS_W'(MAX_BLOCK_BITS);

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [MAX_DISKS-1:0] column_bits;
        logic [MAX_DISKS-1:0] erased_mask;
        logic                 last_of_set;
    } t_in;

    typedef struct packed {
        logic                      result_kind;
        logic [MAX_BLOCK_BITS-1:0] data_word;
        logic [BITS_W-1:0]         word_bits;
        logic [DISK_W-1:0]         source_disk;
        logic                      set_valid;
        logic                      last_result;
    } t_out;

    // merge verdict handed back to the lanes
    typedef struct packed {
        logic rebuild;   // exactly one erased bit, set still good
        logic value;     // rebuilt bit value
        logic set_bad;   // this column breaks the set
    } t_fix;

    // block flush request into the drain buffer
    typedef struct packed {
        logic [MAX_DISKS-1:0] pend;
        logic                 status;
        logic                 set_valid;
        logic [BITS_W-1:0]    held;
    } t_flush;

endpackage

// ===== rtl/core/raid_parity_column_rebuild_top.sv =====
// Top level of the RAID parity column rebuild block: control, lanes, merge and drain.
//
// One disk column is accepted per clock while o_stall is low. Each of the six disk
// lanes checks its bit and keeps a 64-bit block shift store; the merge stage counts
// erasures and forms the parity, so a single erased bit is rebuilt in the same cycle.
// When a column ends a block (or the set), the block words are copied into a drain
// buffer that sends one result per cycle while i_stall is low: one word per data
// disk, then the status at set end. A column that ends a block is held off (o_stall)
// while the previous block is still draining. A block flushes n-1 words for n disks
// (n words when the parity disk sits past the count), plus one status at set end.
// Configuration writes are always ready and take effect on the next column.
module raid_parity_column_rebuild_top
    import rpcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // column requests
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    // result requests
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [2:0]         r_disk_count;
    logic               r_parity_odd;
    logic [BITS_W-1:0]  r_block_bits;

    logic [COL_W-1:0]   r_col, n_col;
    logic [2:0]         r_parity_disk, n_parity_disk;
    logic               r_set_ok, n_set_ok;

    logic [2:0]         eff_n;
    logic [BITS_W-1:0]  eff_bb;
    logic [MAX_DISKS-1:0] active;
    logic [BITS_W-1:0]  held;
    logic               blk_end;
    logic               accept;
    logic               drain_free;
    logic               cfg_we;
    logic [2:0]         parity_inc;
    logic [MAX_BLOCK_BITS-1:0] wmask;

    logic [MAX_DISKS-1:0]      lane_er;
    logic [MAX_DISKS-1:0]      lane_par;
    logic [MAX_BLOCK_BITS-1:0] lane_word [MAX_DISKS];
    logic [MAX_BLOCK_BITS-1:0] flush_words [MAX_DISKS];
    t_fix                      fix;
    t_flush                    flush;

    // ---- configuration ----
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_count <= RST_DISK_COUNT;
            r_parity_odd <= RST_PARITY_ODD;
            r_block_bits <= RST_BLOCK_BITS;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_DISK_COUNT: r_disk_count <= i_cfg_data[2:0];
                CFG_PARITY_ODD: r_parity_odd <= i_cfg_data[0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp configuration to the supported range
    always_comb begin
        if (r_disk_count < 3'd2) begin
            eff_n = 3'd2;
        end else if (r_disk_count > 3'(MAX_DISKS)) begin
            eff_n = 3'(MAX_DISKS);
        end else begin
            eff_n = r_disk_count;
        end
        if (r_block_bits == '0) begin
            eff_bb = BITS_W'(1);
        end else if (r_block_bits > BITS_W'(MAX_BLOCK_BITS)) begin
            eff_bb = BITS_W'(MAX_BLOCK_BITS);
        end else begin
            eff_bb = r_block_bits;
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_DISKS; j++) begin
            active[j] = 3'(j) < eff_n;
        end
    end

    // ---- column control ----
    assign held    = BITS_W'(r_col) + BITS_W'(1);
    assign blk_end = (held >= eff_bb) || i_data.last_of_set;
    assign o_stall = blk_end && !drain_free;
    assign accept  = i_valid && !o_stall;

    assign parity_inc = r_parity_disk + 3'd1;

    always_comb begin
        n_col         = r_col;
        n_parity_disk = r_parity_disk;
        n_set_ok      = r_set_ok;
        if (accept) begin
            n_set_ok = r_set_ok && !fix.set_bad;
            if (blk_end) begin
                n_col         = '0;
                n_parity_disk = (parity_inc >= eff_n) ? 3'd0 : parity_inc;
            end else begin
                n_col = held[COL_W-1:0];
            end
            if (i_data.last_of_set) begin
                n_parity_disk = 3'd0;
                n_set_ok      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_parity_disk <= 3'd0;
            r_set_ok      <= 1'b1;
        end else begin
            r_col         <= n_col;
            r_parity_disk <= n_parity_disk;
            r_set_ok      <= n_set_ok;
        end
    end

    // ---- lanes and merge ----
    for (genvar g = 0; g < MAX_DISKS; g++) begin : g_lane
        rpcr_lane u_lane (
            .i_clk       (i_clk),
            .i_shift     (accept),
            .i_active    (active[g]),
            .i_bit       (i_data.column_bits[g]),
            .i_erased    (i_data.erased_mask[g]),
            .i_fix       (fix),
            .o_er        (lane_er[g]),
            .o_par       (lane_par[g]),
            .o_word_next (lane_word[g])
        );
    end

    rpcr_merge u_merge (
        .i_er         (lane_er),
        .i_par        (lane_par),
        .i_parity_odd (r_parity_odd),
        .i_set_ok     (r_set_ok),
        .o_fix        (fix)
    );

    // ---- flush into the drain buffer ----
    assign wmask = {MAX_BLOCK_BITS{1'b1}} >> (BITS_W'(MAX_BLOCK_BITS) - held);

    always_comb begin
        for (int j = 0; j < MAX_DISKS; j++) begin
            flush_words[j] = lane_word[j] & wmask;
            // parity disk at or beyond the count skips nothing
            flush.pend[j]  = active[j] && (3'(j) != r_parity_disk);
        end
        flush.status    = i_data.last_of_set;
        flush.set_valid = r_set_ok && !fix.set_bad;
        flush.held      = held;
    end

    rpcr_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && blk_end),
        .i_flush (flush),
        .i_words (flush_words),
        .o_free  (drain_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    a_col_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !blk_end) |=> (BITS_W'(r_col) < eff_bb || $past(cfg_we)
            || $changed(r_block_bits)))
        else $error("column index ran past the block size");

    a_set_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.last_of_set) |=> (r_col == '0 && r_parity_disk == 3'd0 && r_set_ok))
        else $error("set end did not restore column control");

    a_stall_only_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (blk_end && !drain_free))
        else $error("column stalled without a pending flush");
`endif

endmodule

// ===== rtl/core/rpcr_lane.sv =====
// One disk lane: parity contribution and block shift store for a single disk.
module rpcr_lane
    import rpcr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic                      i_active,
    input  logic                      i_bit,
    input  logic                      i_erased,
    input  t_fix                      i_fix,
    output logic                      o_er,
    output logic                      o_par,
    output logic [MAX_BLOCK_BITS-1:0] o_word_next
);

    logic [MAX_BLOCK_BITS-1:0] r_word;
    logic                      n_bit;

    assign o_er  = i_active & i_erased;
    assign o_par = i_active & ~i_erased & i_bit;

    // erased bit takes the rebuilt value, otherwise the raw column bit
    assign n_bit       = (i_fix.rebuild && o_er) ? i_fix.value : i_bit;
    assign o_word_next = {r_word[MAX_BLOCK_BITS-2:0], n_bit};

    always_ff @(posedge i_clk) begin
        if (i_shift && i_active) begin
            r_word <= o_word_next;
        end
    end

endmodule

// ===== rtl/core/rpcr_merge.sv =====
// Merge stage: combines the lanes' erasure and parity bits into one column verdict.
module rpcr_merge
    import rpcr_pkg::*;
(
    input  logic [MAX_DISKS-1:0] i_er,
    input  logic [MAX_DISKS-1:0] i_par,
    input  logic                 i_parity_odd,
    input  logic                 i_set_ok,
    output t_fix                 o_fix
);

    logic [CNT_W-1:0] cnt;
    logic             chk;

    always_comb begin
        cnt = '0;
        for (int j = 0; j < MAX_DISKS; j++) begin
            cnt = cnt + CNT_W'(i_er[j]);
        end
    end

    assign chk = i_parity_odd ^ (^i_par);

    assign o_fix.rebuild = i_set_ok && (cnt == CNT_W'(1));
    assign o_fix.value   = chk;
    assign o_fix.set_bad = i_set_ok && ((cnt >= CNT_W'(2)) || ((cnt == '0) && chk));

endmodule

// ===== rtl/core/rpcr_drain.sv =====
// Drain buffer: holds a block, emits its words and status one per unstalled cycle.
module rpcr_drain
    import rpcr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  t_flush                    i_flush,
    input  logic [MAX_BLOCK_BITS-1:0] i_words [MAX_DISKS],
    output logic                      o_free,
    output logic                      o_valid,
    input  logic                      i_stall,
    output t_out                      o_data
);

    logic [MAX_BLOCK_BITS-1:0] r_words [MAX_DISKS];
    logic [MAX_DISKS-1:0]      r_pend, n_pend;
    logic                      r_stat, n_stat;
    logic                      r_set_valid;
    logic [BITS_W-1:0]         r_held;
    logic                      r_ovld, n_ovld;
    t_out                      r_out, n_out;

    logic                      busy;
    logic                      out_take;
    logic                      emit;
    logic                      emit_last;
    logic [DISK_W-1:0]         sel;
    logic [MAX_DISKS-1:0]      pend_rest;

    assign busy     = (|r_pend) || r_stat;
    assign out_take = r_ovld && !i_stall;
    assign emit     = busy && (!r_ovld || out_take);

    // lowest pending disk goes first
    always_comb begin
        sel = '0;
        for (int j = MAX_DISKS - 1; j >= 0; j--) begin
            if (r_pend[j]) begin
                sel = DISK_W'(j);
            end
        end
    end

    always_comb begin
        pend_rest = r_pend;
        pend_rest[sel] = 1'b0;
    end

    assign emit_last = (|r_pend) ? ((pend_rest == '0) && !r_stat) : 1'b1;
    assign o_free    = !busy || (emit && emit_last);

    always_comb begin
        n_pend = r_pend;
        n_stat = r_stat;
        if (emit) begin
            if (|r_pend) begin
                n_pend = pend_rest;
            end else begin
                n_stat = 1'b0;
            end
        end
        if (i_load) begin
            n_pend = i_flush.pend;
            n_stat = i_flush.status;
        end
    end

    always_comb begin
        n_out = r_out;
        if (|r_pend) begin
            n_out.result_kind = KIND_DATA;
            n_out.data_word   = r_words[sel];
            n_out.word_bits   = r_held;
            n_out.source_disk = sel;
        end else begin
            n_out.result_kind = KIND_STATUS;
            n_out.data_word   = '0;
            n_out.word_bits   = '0;
            n_out.source_disk = '0;
        end
        n_out.set_valid   = r_set_valid;
        n_out.last_result = emit_last;
    end

    always_comb begin
        n_ovld = r_ovld;
        if (emit) begin
            n_ovld = 1'b1;
        end else if (out_take) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_stat <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_stat <= n_stat;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words     <= i_words;
            r_set_valid <= i_flush.set_valid;
            r_held      <= i_flush.held;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("flush loaded while drain buffer still holds results");

    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_kind == KIND_STATUS)
            |-> (o_data.last_result && o_data.word_bits == '0))
        else $error("status result not last or carries word bits");

    a_data_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_kind == KIND_DATA)
            |-> (o_data.word_bits != '0 && o_data.source_disk < DISK_W'(MAX_DISKS)))
        else $error("data result with no bits or bad source disk");

    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last && !i_load) |=> !busy)
        else $error("drain still busy after emitting its last result");
`endif

endmodule
